>>> rtl/core/euler_angles_to_quaternion_assert.svh
// Assertion macros for the Euler-to-quaternion block
`ifndef EULER_ANGLES_TO_QUATERNION_ASSERT_SVH
`define EULER_ANGLES_TO_QUATERNION_ASSERT_SVH

`define EAQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define EAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/eaq_pkg.sv
package eaq_pkg;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int FRAC_BITS_DEF    = 14;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 32;
    localparam int OUT_W            = 16;
    localparam int IN_W             = 16;
    localparam int QW               = 34;
    localparam int ZW               = 34;
    localparam logic signed [QW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [QW-1:0] q30_t;

    typedef struct packed {
        logic signed [IN_W-1:0] roll;
        logic signed [IN_W-1:0] pitch;
        logic signed [IN_W-1:0] yaw;
    } euler_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
        logic signed [OUT_W-1:0] quat_w;
    } quat_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0: r = 34'sd536870912;
            1: r = 34'sd316933406;
            2: r = 34'sd167458907;
            3: r = 34'sd85004756;
            4: r = 34'sd42667331;
            5: r = 34'sd21354465;
            6: r = 34'sd10679838;
            7: r = 34'sd5339733;
            8: r = 34'sd2669907;
            9: r = 34'sd1334959;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            24: r = 34'sd41;
            25: r = 34'sd20;
            26: r = 34'sd10;
            27: r = 34'sd5;
            28: r = 34'sd3;
            29: r = 34'sd1;
            30: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

>>> rtl/core/eaq_stream_if.sv
interface eaq_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/eaq_cordic_lane.sv
// One pipelined rotation-mode CORDIC lane: one stage per step.
module eaq_cordic_lane #(
    parameter int ANGLE_BITS   = eaq_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = eaq_pkg::CORDIC_STEPS_DEF
) (
    input  logic                       clk,
    input  logic                       adv,
    input  logic [eaq_pkg::IN_W-1:0]   angle,
    output eaq_pkg::q30_t              cos_q,
    output eaq_pkg::q30_t              sin_q
);
    import eaq_pkg::*;

    localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    logic signed [ANGLE_BITS-1:0] a;
    logic signed [ZW-1:0]         z0;
    q30_t                         x_reg [NS+1];
    q30_t                         y_reg [NS+1];
    logic signed [ZW-1:0]         z_reg [NS+1];

    assign a = ANGLE_BITS'(angle);

    generate
        if (ANGLE_BITS <= 31)
        begin : g_sh
            assign z0 = ZW'(a) <<< (31 - ANGLE_BITS);
        end
        else
        begin : g_half
            assign z0 = ZW'(a >>> 1);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= z0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < NS; i++)
        begin : g_step
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!z_reg[i][ZW-1])
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - atan_entry(i);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + atan_entry(i);
                    end
                end
            end
        end
    endgenerate

    assign cos_q = x_reg[NS];
    assign sin_q = y_reg[NS];
endmodule

>>> rtl/core/eaq_merge.sv
// Combines the three lanes' cos/sin pairs into the quaternion.
module eaq_merge #(
    parameter int FRAC_BITS = eaq_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          adv,
    input  eaq_pkg::q30_t cr,
    input  eaq_pkg::q30_t sr,
    input  eaq_pkg::q30_t cp,
    input  eaq_pkg::q30_t sp,
    input  eaq_pkg::q30_t cy,
    input  eaq_pkg::q30_t sy,
    output eaq_pkg::quat_t quat
);
    import eaq_pkg::*;

    localparam int PW = 2 * QW;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< 29;

    function automatic q30_t mq(input q30_t a, input q30_t b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b) + HALF;
        return QW'(p >>> 30);
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [QW:0] v);
        logic signed [QW+1:0] t;
        logic signed [QW+1:0] lim;
        lim = (QW+2)'(1) <<< FRAC_BITS;
        if (FRAC_BITS < 30)
            t = ((QW+2)'(v) + ((QW+2)'(1) <<< (29 - FRAC_BITS)))
                >>> (30 - FRAC_BITS);
        else
            t = (QW+2)'(v);
        if (t > lim)
            t = lim;
        if (t < -lim)
            t = -lim;
        return t[OUT_W-1:0];
    endfunction

    // roll factor times pitch factor first, then times the yaw factor
    q30_t crcp_reg, crsp_reg, srcp_reg, srsp_reg, cy1_reg, sy1_reg;
    q30_t t_reg [8];
    quat_t q_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            crcp_reg <= mq(cr, cp);
            crsp_reg <= mq(cr, sp);
            srcp_reg <= mq(sr, cp);
            srsp_reg <= mq(sr, sp);
            cy1_reg  <= cy;
            sy1_reg  <= sy;
            t_reg[0] <= mq(srcp_reg, cy1_reg);
            t_reg[1] <= mq(crsp_reg, sy1_reg);
            t_reg[2] <= mq(crsp_reg, cy1_reg);
            t_reg[3] <= mq(srcp_reg, sy1_reg);
            t_reg[4] <= mq(crcp_reg, sy1_reg);
            t_reg[5] <= mq(srsp_reg, cy1_reg);
            t_reg[6] <= mq(crcp_reg, cy1_reg);
            t_reg[7] <= mq(srsp_reg, sy1_reg);
            q_reg.quat_x <= to_out((QW+1)'(t_reg[0]) - (QW+1)'(t_reg[1]));
            q_reg.quat_y <= to_out((QW+1)'(t_reg[2]) + (QW+1)'(t_reg[3]));
            q_reg.quat_z <= to_out((QW+1)'(t_reg[4]) - (QW+1)'(t_reg[5]));
            q_reg.quat_w <= to_out((QW+1)'(t_reg[6]) + (QW+1)'(t_reg[7]));
        end
    end

    assign quat = q_reg;
endmodule

>>> rtl/core/euler_angles_to_quaternion.sv
// Registered path: input register, CORDIC step registers, pair products, triple products, output rounding.
// Throughput: one transfer per cycle; the whole pipeline stalls only while
// a result waits at the output and is not taken.
// Reset: rst_n asynchronous, clears valid bits only; no other state.
module euler_angles_to_quaternion #(
    parameter int ANGLE_BITS   = eaq_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS    = eaq_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = eaq_pkg::CORDIC_STEPS_DEF
) (
    input logic   clk,
    input logic   rst_n,
    eaq_stream_if.sink   in_ch,
    eaq_stream_if.source out_ch
);
    import eaq_pkg::*;

    localparam int NS  = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int LAT = NS + 4;

    logic [LAT-1:0] vld_reg;
    logic           adv;
    euler_t         e;
    q30_t           cr, sr, cp, sp, cy, sy;
    quat_t          q;

    assign e      = in_ch.data;
    assign adv    = !vld_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
    end

    eaq_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .clk(clk), .adv(adv), .angle(e.roll), .cos_q(cr), .sin_q(sr));
    eaq_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .clk(clk), .adv(adv), .angle(e.pitch), .cos_q(cp), .sin_q(sp));
    eaq_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .clk(clk), .adv(adv), .angle(e.yaw), .cos_q(cy), .sin_q(sy));

    eaq_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .clk(clk), .adv(adv), .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
        .quat(q));

    assign out_ch.valid = vld_reg[LAT-1];
    assign out_ch.data  = q;
endmodule

>>> rtl/core/eaq_checker.sv
`include "euler_angles_to_quaternion_assert.svh"
module eaq_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input eaq_pkg::quat_t       out_data
);
    import eaq_pkg::*;

    `EAQ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped while stalled")
    `EAQ_ASSERT_IMPL(a_ready, clk, rst_n, !out_valid || out_ready, in_ready, "input stalled with free output")
    `EAQ_ASSERT_IMPL(a_xsat, clk, rst_n, out_valid, $signed(out_data.quat_x) <= 16384 && $signed(out_data.quat_x) >= -16384, "quat_x out of range")
    `EAQ_ASSERT_IMPL(a_wsat, clk, rst_n, out_valid, $signed(out_data.quat_w) <= 16384 && $signed(out_data.quat_w) >= -16384, "quat_w out of range")
endmodule

bind euler_angles_to_quaternion eaq_checker u_eaq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import eaq_pkg::*;

    localparam int ITEMS_RANDOM = 1130;
    localparam int LIMIT_CYCLES = 400000;
    localparam int LAT = CORDIC_STEPS_DEF + 4;

    logic clk;
    logic rst_n;

    eaq_stream_if #(.payload_t(euler_t)) in_ch ();
    eaq_stream_if #(.payload_t(quat_t))  out_ch ();

    euler_angles_to_quaternion i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    euler_t pending_angles[$];
    quat_t  expected_quats[$];
    int     errors = 0;
    int     cycle_count = 0;
    bit     calm;
    bit     hold_req;
    int     hold_cnt;
    int     src_gap;
    int     snk_gap;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    function automatic longint half_turn(logic signed [15:0] a);
        longint v;
        v = a;
        return v * (longint'(1) << 15);
    endfunction

    function automatic longint round_q30(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic longint atan_q31(int i);
        longint t [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5339733, 2669907, 1334959, 667544, 333772,
            166886, 83443, 41722, 20861};
        return t[i];
    endfunction

    task automatic rotate_unit(input longint ang, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = 652032874;
        y = 0;
        z = ang;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_q31(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_q31(i);
            end
        end
        c = x;
        s = y;
    endtask

    function automatic logic [15:0] to_q14(longint v);
        longint r;
        r = (v + (longint'(1) << 15)) >>> 16;
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic longint prod3(longint a, longint b, longint c);
        return round_q30(round_q30(a, b), c);
    endfunction

    task automatic predict_quat(input euler_t e, output quat_t q);
        longint cr, sr, cp, sp, cy, sy;
        rotate_unit(half_turn(e.roll), cr, sr);
        rotate_unit(half_turn(e.pitch), cp, sp);
        rotate_unit(half_turn(e.yaw), cy, sy);
        q.quat_x = to_q14(prod3(sr, cp, cy) - prod3(cr, sp, sy));
        q.quat_y = to_q14(prod3(cr, sp, cy) + prod3(sr, cp, sy));
        q.quat_z = to_q14(prod3(cr, cp, sy) - prod3(sr, sp, cy));
        q.quat_w = to_q14(prod3(cr, cp, cy) + prod3(sr, sp, sy));
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what,
            $signed(got), $signed(exp), cycle_count);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        quat_t q;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            src_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_quat(in_ch.data, q);
                expected_quats.push_back(q);
                void'(pending_angles.pop_front());
            end
            if ((in_ch.valid && !in_ch.ready))
                ;
            else if (src_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (pending_angles.size() > 0)
            begin
                if (!calm && $urandom_range(0, 9) == 0)
                begin
                    in_ch.valid <= 1'b0;
                    src_gap <= $urandom_range(0, 12);
                end
                else
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending_angles[0];
                end
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        quat_t exp_q;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            snk_gap <= 0;
            hold_cnt <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_quats.size() == 0)
                begin
                    $display("unexpected result at cycle %0d", cycle_count);
                    errors++;
                end
                else
                begin
                    exp_q = expected_quats.pop_front();
                    if (out_ch.data.quat_x !== exp_q.quat_x)
                        report("quat_x", out_ch.data.quat_x, exp_q.quat_x);
                    if (out_ch.data.quat_y !== exp_q.quat_y)
                        report("quat_y", out_ch.data.quat_y, exp_q.quat_y);
                    if (out_ch.data.quat_z !== exp_q.quat_z)
                        report("quat_z", out_ch.data.quat_z, exp_q.quat_z);
                    if (out_ch.data.quat_w !== exp_q.quat_w)
                        report("quat_w", out_ch.data.quat_w, exp_q.quat_w);
                end
            end
            if (hold_req && hold_cnt == 0)
            begin
                hold_cnt <= 300;
                out_ch.ready <= 1'b0;
            end
            else if (hold_cnt > 1)
            begin
                hold_cnt <= hold_cnt - 1;
                out_ch.ready <= 1'b0;
            end
            else if (hold_cnt == 1)
            begin
                hold_cnt <= -1;
                out_ch.ready <= 1'b1;
            end
            else if (snk_gap > 0)
            begin
                snk_gap <= snk_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                snk_gap <= $urandom_range(0, 12);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] edges [8] = '{16'h0000, 16'h7fff, 16'h8000, 16'h8001, 16'hffff,
            16'h4000, 16'hc000, 16'h0001};
        euler_t e;
        calm = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            e.roll = edges[i]; e.pitch = edges[(i + 3) % 8]; e.yaw = edges[(i + 5) % 8];
            pending_angles.push_back(e);
        end
        for (int i = 0; i < 8; i++)
        begin
            e.roll = edges[i]; e.pitch = edges[i]; e.yaw = edges[i];
            pending_angles.push_back(e);
        end
        e = '{16'h4000, 16'h4000, 16'h0000}; pending_angles.push_back(e);
        e = '{16'h0000, 16'h4000, 16'h4000}; pending_angles.push_back(e);
        e = '{16'h5555, 16'haaaa, 16'h2000}; pending_angles.push_back(e);
        e = '{16'haaaa, 16'h5555, 16'he000}; pending_angles.push_back(e);
        for (int i = 0; i < ITEMS_RANDOM; i++)
        begin
            e.roll = pick_angle(); e.pitch = pick_angle(); e.yaw = pick_angle();
            pending_angles.push_back(e);
            if (i == 200)
            begin
                wait (pending_angles.size() < 900);
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
        end
        wait (pending_angles.size() < 150);
        calm = 1'b1;
        wait (pending_angles.size() == 0);
        wait (expected_quats.size() == 0);
        repeat (LAT + 10) @(posedge clk);
        if (errors == 0 && expected_quats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/eaq_pkg.sv
rtl/core/eaq_stream_if.sv
rtl/core/eaq_cordic_lane.sv
rtl/core/eaq_merge.sv
rtl/core/euler_angles_to_quaternion.sv
rtl/core/eaq_checker.sv
verif/tb.sv
